>>> rtl/core/arpeggio_note_sequencer_assert.svh
// Assertion macros for the arpeggio note sequencer
`ifndef ARPEGGIO_NOTE_SEQUENCER_ASSERT_SVH
`define ARPEGGIO_NOTE_SEQUENCER_ASSERT_SVH
`ifndef SYNTHESIS
`define ANS_ASSERT_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define ANS_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define ANS_ASSERT_IMPL(label, clk, rst_n, a, c)
`define ANS_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

>>> rtl/core/ans_pkg.sv
package ans_pkg;
    localparam logic [1:0] CMD_ON   = 2'd0;
    localparam logic [1:0] CMD_OFF  = 2'd1;
    localparam logic [1:0] CMD_ALL  = 2'd2;
    localparam logic [1:0] CMD_TICK = 2'd3;

    localparam logic [3:0] PM_UP       = 4'd0;
    localparam logic [3:0] PM_DOWN     = 4'd1;
    localparam logic [3:0] PM_UPDOWN   = 4'd2;
    localparam logic [3:0] PM_PLAYED   = 4'd3;
    localparam logic [3:0] PM_CONVERGE = 4'd4;
    localparam logic [3:0] PM_DIVERGE  = 4'd5;
    localparam logic [3:0] PM_INSIDE   = 4'd6;
    localparam logic [3:0] PM_OUTSIDE  = 4'd7;
    localparam logic [3:0] PM_CHORD    = 4'd8;

    localparam logic REG_MODE = 1'b0;
    localparam logic REG_SPAN = 1'b1;

    localparam logic [6:0] TOP_KEY   = 7'd127;
    localparam int         SEMITONES = 12;
    localparam int         RESULT_CAP = 16;

    // commands from controller to datapath
    typedef struct packed {
        logic load;       // capture input item
        logic edit_on;    // note-on edit pass step
        logic edit_off;   // note-off compaction step
        logic clear;
        logic sort_step;  // one compare-exchange step
        logic sort_init;
        logic mod_init;   // start step_count remainders
        logic mod_step;
        logic pick;       // compute index and octave
        logic fetch;      // read note, form result
        logic chord_next;
        logic step_inc;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic sort_done;
        logic mod_done;
        logic edit_done;
        logic empty;
        logic in_range;   // formed note <= 127
        logic chord_end;
        logic chord_last;
        logic bad_mode;
        logic is_chord;
    } t_sts;
endpackage

>>> rtl/core/ans_ctrl.sv
module ans_ctrl
    import ans_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_cmd,
    input  logic       i_out_free,
    input  t_sts       i_sts,
    output logic       o_in_ready,
    output t_cmd       o_cmd
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ON    = 4'd1;
    localparam logic [3:0] S_OFF   = 4'd2;
    localparam logic [3:0] S_CHK   = 4'd3;
    localparam logic [3:0] S_SORT  = 4'd4;
    localparam logic [3:0] S_MOD   = 4'd5;
    localparam logic [3:0] S_PICK  = 4'd6;
    localparam logic [3:0] S_FETCH = 4'd7;
    localparam logic [3:0] S_EMIT  = 4'd8;

    logic [3:0] r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    unique case (i_cmd)
                        CMD_ON:   n_state = S_ON;
                        CMD_OFF:  n_state = S_OFF;
                        CMD_ALL:  o_cmd.clear = 1'b1;
                        CMD_TICK: n_state = S_CHK;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_ON: begin
                o_cmd.edit_on = 1'b1;
                if (i_sts.edit_done) n_state = S_IDLE;
            end
            S_OFF: begin
                o_cmd.edit_off = 1'b1;
                if (i_sts.edit_done) n_state = S_IDLE;
            end
            S_CHK: begin
                if (i_sts.empty || i_sts.bad_mode) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.sort_init = 1'b1;
                    o_cmd.mod_init  = 1'b1;
                    n_state = S_SORT;
                end
            end
            S_SORT: begin
                o_cmd.sort_step = 1'b1;
                if (i_sts.sort_done) n_state = S_MOD;
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (i_sts.mod_done) n_state = S_PICK;
            end
            S_PICK: begin
                o_cmd.pick     = 1'b1;
                o_cmd.step_inc = 1'b1;
                n_state = S_FETCH;
            end
            S_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.is_chord) begin
                    if (i_sts.chord_end) begin
                        n_state = S_IDLE;
                    end else if (!i_sts.in_range) begin
                        o_cmd.chord_next = 1'b1;
                        n_state = S_FETCH;
                    end else if (i_out_free) begin
                        o_cmd.out_load   = 1'b1;
                        o_cmd.chord_next = 1'b1;
                        n_state = i_sts.chord_last ? S_IDLE : S_FETCH;
                    end
                end else if (!i_sts.in_range) begin
                    n_state = S_IDLE;
                end else if (i_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

>>> rtl/core/ans_dpath.sv
module ans_dpath
    import ans_pkg::*;
#(
    parameter int HELD_NOTES = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [6:0] i_key,
    input  logic [6:0] i_strike,
    input  logic [3:0] i_mode,
    input  logic [1:0] i_span,
    input  t_cmd       i_ctl,
    output t_sts       o_sts,
    output logic [6:0] o_key,
    output logic [6:0] o_strike,
    output logic       o_last
);
    localparam int IW = (HELD_NOTES > 1) ? $clog2(HELD_NOTES) : 1;
    localparam int CW = $clog2(HELD_NOTES + 1);
    // total = len*octs < 4*HELD_NOTES; reflected period < 8*HELD_NOTES
    localparam int TW = $clog2(8 * HELD_NOTES + 1);

    logic [6:0]    r_keys [HELD_NOTES];
    logic [6:0]    r_strk [HELD_NOTES];
    logic [IW-1:0] r_ord  [HELD_NOTES];
    logic [CW-1:0] r_count;
    logic [31:0]   r_step;
    logic [6:0]    r_k, r_v;
    logic [CW-1:0] r_i, r_w;
    logic          r_found;
    logic [CW-1:0] r_pass;
    logic          r_par;
    logic [5:0]    r_bit;
    logic [TW-1:0] r_rs, r_rr;   // step mod total (mod octs in chord mode), step mod reflection
    logic [IW-1:0] r_idx;
    logic [1:0]    r_oct;
    logic [CW-1:0] r_ci, r_cn;
    logic [6:0]    r_note, r_nv;
    logic          r_nok;

    logic [1:0]    octs;
    logic [TW-1:0] len_t, total, refl;
    logic [CW-1:0] cnt_m1;
    assign octs   = (i_span == 2'd0) ? 2'd1 : i_span;
    assign len_t  = TW'(r_count);
    assign total  = len_t * TW'(octs);
    assign refl   = (total > TW'(1)) ? TW'(2 * total - 2) : TW'(1);
    assign cnt_m1 = r_count - CW'(1);

    // remainder of step_count, one bit per cycle (MSB first)
    logic [TW:0] rs_sh, rr_sh;
    logic [TW-1:0] oct_div;
    assign rs_sh = {r_rs, r_step[r_bit[4:0]]};
    assign rr_sh = {r_rr, r_step[r_bit[4:0]]};
    assign oct_div = (i_mode == PM_CHORD) ? TW'(octs) : total;

    // index/octave pick helpers: sw in [0,total), split by len
    logic [TW-1:0] s_w, s_in, s_pair, sw_v, sw_len;
    logic [1:0]    oct_v;
    logic [TW-1:0] idx_v;
    logic signed [TW+1:0] dv;
    always_comb begin
        s_w    = r_rs;
        sw_v   = s_w;
        s_in   = '0;
        s_pair = '0;
        dv     = '0;
        unique case (i_mode)
            PM_UPDOWN: sw_v = (r_rr >= total) ? TW'(2 * total - 2 - r_rr) : r_rr;
            PM_CONVERGE: begin
                s_pair = s_w >> 1;
                sw_v = (total <= 1) ? '0 : (s_w[0] ? TW'(total - 1 - s_pair) : s_pair);
            end
            PM_DIVERGE: begin
                s_pair = s_w >> 1;
                dv = (TW+2)'(s_w[0]
                     ? $signed({2'b0, total >> 1}) - 1 - $signed({2'b0, s_pair})
                     : $signed({2'b0, total >> 1}) + $signed({2'b0, s_pair}));
                if (total <= 1) sw_v = '0;
                else if (dv < 0) sw_v = '0;
                else if (dv > $signed({2'b0, total}) - 1) sw_v = TW'(total - 1);
                else sw_v = TW'(dv);
            end
            default: sw_v = s_w;
        endcase
        // split sw_v into octave and index (octs <= 3: compare-subtract)
        oct_v  = 2'd0;
        sw_len = sw_v;
        if (sw_len >= len_t) begin sw_len = sw_len - len_t; oct_v = 2'd1; end
        if (sw_len >= len_t) begin sw_len = sw_len - len_t; oct_v = 2'd2; end
        s_in  = sw_len;
        idx_v = sw_len;
        unique case (i_mode)
            PM_DOWN: begin
                oct_v = octs - 2'd1 - oct_v;
                idx_v = TW'(len_t - 1 - s_in);
            end
            PM_INSIDE, PM_OUTSIDE: begin
                s_pair = s_in >> 1;
                idx_v = (len_t <= 1) ? '0
                      : (s_in[0] ? TW'(len_t - 1 - s_pair) : s_pair);
                if (i_mode == PM_OUTSIDE) idx_v = TW'(len_t - 1 - idx_v);
            end
            default: ;
        endcase
    end

    // insertion-free sort: odd-even transposition, HELD_NOTES passes
    logic [IW-1:0] ord_n [HELD_NOTES];
    always_comb begin
        for (int j = 0; j < HELD_NOTES; j++) ord_n[j] = r_ord[j];
        for (int j = 0; j + 1 < HELD_NOTES; j++) begin
            if ((j[0] == r_par) && (CW'(j + 1) < r_count) &&
                (r_keys[r_ord[j]] > r_keys[r_ord[j+1]])) begin
                ord_n[j]   = r_ord[j+1];
                ord_n[j+1] = r_ord[j];
            end
        end
    end

    logic [IW-1:0] sel;
    logic [6:0]    base_key;
    logic [8:0]    note_sum;
    assign sel      = (i_mode == PM_CHORD) ? r_ord[r_ci[IW-1:0]] : r_ord[r_idx];
    assign base_key = r_keys[sel];
    assign note_sum = {2'b0, base_key} + 9'(SEMITONES * r_oct);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_step  <= '0;
            r_found <= 1'b0;
            r_i     <= '0;
            r_w     <= '0;
        end else begin
            if (i_ctl.load) begin
                r_k     <= i_key;
                r_v     <= i_strike;
                r_i     <= '0;
                r_w     <= '0;
                r_found <= 1'b0;
            end
            if (i_ctl.clear) r_count <= '0;
            // note-on: one entry per cycle; matched entry shifted out
            if (i_ctl.edit_on) begin
                if (r_i < r_count) begin
                    if (r_found) begin
                        r_keys[r_i[IW-1:0] - IW'(1)] <= r_keys[r_i[IW-1:0]];
                        r_strk[r_i[IW-1:0] - IW'(1)] <= r_strk[r_i[IW-1:0]];
                    end else if (r_keys[r_i[IW-1:0]] == r_k) begin
                        r_found <= 1'b1;
                    end
                    r_i <= r_i + CW'(1);
                end else if (r_found) begin
                    r_keys[cnt_m1[IW-1:0]] <= r_k;
                    r_strk[cnt_m1[IW-1:0]] <= r_v;
                end else if (r_count == CW'(HELD_NOTES)) begin
                    for (int j = 0; j + 1 < HELD_NOTES; j++) begin
                        r_keys[j] <= r_keys[j+1];
                        r_strk[j] <= r_strk[j+1];
                    end
                    r_keys[HELD_NOTES-1] <= r_k;
                    r_strk[HELD_NOTES-1] <= r_v;
                end else begin
                    r_keys[r_count[IW-1:0]] <= r_k;
                    r_strk[r_count[IW-1:0]] <= r_v;
                    r_count <= r_count + CW'(1);
                end
            end
            if (i_ctl.edit_off) begin
                if (r_i < r_count) begin
                    if (r_keys[r_i[IW-1:0]] != r_k) begin
                        r_keys[r_w[IW-1:0]] <= r_keys[r_i[IW-1:0]];
                        r_strk[r_w[IW-1:0]] <= r_strk[r_i[IW-1:0]];
                        r_w <= r_w + CW'(1);
                    end
                    r_i <= r_i + CW'(1);
                end else begin
                    r_count <= r_w;
                end
            end
            if (i_ctl.step_inc) r_step <= r_step + 32'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pass <= '0;
            r_bit  <= '0;
            r_ci   <= '0;
            r_cn   <= '0;
        end else begin
            if (i_ctl.sort_init) begin
                for (int j = 0; j < HELD_NOTES; j++) r_ord[j] <= IW'(j);
                r_pass <= '0;
                r_par  <= 1'b0;
            end
            if (i_ctl.mod_init) begin
                r_rs   <= '0;
                r_rr   <= '0;
                r_bit  <= 6'd31;
            end
            if (i_ctl.sort_step) begin
                if (i_mode != PM_PLAYED)
                    for (int j = 0; j < HELD_NOTES; j++) r_ord[j] <= ord_n[j];
                r_par  <= ~r_par;
                r_pass <= r_pass + CW'(1);
            end
            if (i_ctl.mod_step) begin
                r_rs  <= (rs_sh >= {1'b0, oct_div}) ? TW'(rs_sh - {1'b0, oct_div})
                                                    : rs_sh[TW-1:0];
                r_rr  <= (rr_sh >= {1'b0, refl}) ? TW'(rr_sh - {1'b0, refl})
                                                 : rr_sh[TW-1:0];
                r_bit <= r_bit - 6'd1;
            end
            if (i_ctl.pick) begin
                if (i_mode == PM_CHORD) begin
                    r_oct <= r_rs[1:0];
                    r_ci  <= '0;
                    r_cn  <= '0;
                end else begin
                    r_oct <= oct_v;
                    r_idx <= (idx_v >= len_t) ? cnt_m1[IW-1:0] : idx_v[IW-1:0];
                end
            end
            if (i_ctl.fetch) begin
                r_note <= note_sum[6:0];
                r_nv   <= r_strk[sel];
                r_nok  <= (note_sum <= {2'b0, TOP_KEY});
            end
            if (i_ctl.chord_next) begin
                r_ci <= r_ci + CW'(1);
                if (i_ctl.out_load) r_cn <= r_cn + CW'(1);
            end
        end
    end

    // chord: last emitted note if no later entry is in range
    logic later_ok;
    always_comb begin
        later_ok = 1'b0;
        for (int j = 0; j < HELD_NOTES; j++)
            if (CW'(j) > r_ci && CW'(j) < r_count &&
                ({2'b0, r_keys[r_ord[j]]} + 9'(SEMITONES * r_oct)) <= {2'b0, TOP_KEY})
                later_ok = 1'b1;
    end

    assign o_sts.sort_done  = (r_pass == CW'(HELD_NOTES - 1)) || (HELD_NOTES < 2);
    assign o_sts.mod_done   = (r_bit == 6'd0);
    assign o_sts.edit_done  = (r_i >= r_count);
    assign o_sts.empty      = (r_count == '0);
    assign o_sts.in_range   = r_nok;
    assign o_sts.chord_end  = (r_ci >= r_count) || (r_cn == CW'(RESULT_CAP));
    assign o_sts.chord_last = !later_ok || (r_cn == CW'(RESULT_CAP - 1));
    assign o_sts.bad_mode   = (i_mode > PM_CHORD);
    assign o_sts.is_chord   = (i_mode == PM_CHORD);

    assign o_key    = r_note;
    assign o_strike = r_nv;
    assign o_last   = (i_mode != PM_CHORD) || o_sts.chord_last;
endmodule

>>> rtl/core/arpeggio_note_sequencer.sv
// channel    dir  fields (tdata / tuser, low bit first)
// s_axis     in   tuser: cmd[1:0]; tdata: key[6:0], strike[13:7]
// m_axis     out  tdata: out_key[6:0], out_strike[13:7]; tlast: final_flag
// cfg        in   index, data (0 pattern_mode, 1 octave_span)
// Note-on/off scan the note table, one entry per cycle.
// A tick runs a sort pass per cycle, then a bit-serial remainder of the step
// counter, then pick, fetch and emit. Chord mode repeats fetch and emit for each
// table entry visited after the pick; empty table or bad mode: back to idle.
// Reset is synchronous, active low; the note table is not cleared.
// A full output register stalls the sequencer until it is taken.
`include "arpeggio_note_sequencer_assert.svh"
module arpeggio_note_sequencer
    import ans_pkg::*;
#(
    parameter int HELD_NOTES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // key, strike, zero fill
    input  logic [1:0]  s_axis_tuser,   // cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // out_key, out_strike, zero fill
    output logic        m_axis_tlast,   // final_flag
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [3:0]  i_cfg_data
);
    logic [3:0] r_mode;
    logic [1:0] r_span;
    t_cmd       ctl;
    t_sts       sts;
    logic [6:0] d_key, d_strike;
    logic       d_last;
    logic       r_ovalid;
    logic [13:0] r_odata;
    logic       r_olast;
    logic       out_free;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= PM_UP;
            r_span <= 2'd1;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_MODE) r_mode <= i_cfg_data;
            else                         r_span <= i_cfg_data[1:0];
        end
    end

    assign out_free = !r_ovalid || m_axis_tready;

    ans_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_cmd      (s_axis_tuser),
        .i_out_free (out_free),
        .i_sts      (sts),
        .o_in_ready (s_axis_tready),
        .o_cmd      (ctl)
    );

    ans_dpath #(.HELD_NOTES(HELD_NOTES)) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_key    (s_axis_tdata[6:0]),
        .i_strike (s_axis_tdata[13:7]),
        .i_mode   (r_mode),
        .i_span   (r_span),
        .i_ctl    (ctl),
        .o_sts    (sts),
        .o_key    (d_key),
        .o_strike (d_strike),
        .o_last   (d_last)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (ctl.out_load) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (ctl.out_load) begin
            r_odata <= {d_strike, d_key};
            r_olast <= d_last;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {2'b00, r_odata};
    assign m_axis_tlast  = r_olast;

    `ANS_ASSERT_IMPL(a_load_free, i_clk, i_rst_n, ctl.out_load, out_free)
    `ANS_ASSERT_IMPL(a_no_accept_busy, i_clk, i_rst_n, ctl.out_load, !s_axis_tready)
    `ANS_ASSERT_NEXT(a_valid_after_load, i_clk, i_rst_n, ctl.out_load, m_axis_tvalid)
endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
    import ans_pkg::*;

    localparam int          TABLE_DEPTH = 16;
    localparam int          SETTLE_CYCLES = 120;
    localparam logic [3:0]  PM_BAD_LO = 4'd9;
    localparam logic [3:0]  PM_BAD_HI = 4'd15;

    typedef struct packed {
        logic [1:0] cmd;
        logic [6:0] key;
        logic [6:0] strike;
    } t_note_event;

    typedef struct packed {
        logic [6:0] key;
        logic [6:0] strike;
        logic       last;
    } t_played_note;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;    // key[6:0], strike[13:7]
    logic [1:0]  s_axis_tuser = '0;    // cmd[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;         // out_key[6:0], out_strike[13:7]
    logic        m_axis_tlast;         // final_flag
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = 1'b0;
    logic [3:0]  i_cfg_data = '0;

    arpeggio_note_sequencer dut (.*);

    always #1 i_clk = ~i_clk;

    t_note_event  pending_events[$];
    t_played_note expected_notes[$];
    int           fail_count = 0;
    bit           calm = 1'b0;

    // shadow of the sequencer state
    logic [6:0]  sh_keys[TABLE_DEPTH];
    logic [6:0]  sh_strikes[TABLE_DEPTH];
    int          sh_count = 0;
    logic [31:0] sh_steps = '0;
    logic [3:0]  sh_mode = PM_UP;
    logic [1:0]  sh_span = 2'd1;

    function automatic int unsigned walk_in(int unsigned s, int unsigned len);
        if (len <= 1) return 0;
        return s[0] ? (len - 1 - s / 2) : s / 2;
    endfunction

    function automatic int unsigned walk_out(int unsigned s, int unsigned len);
        int mid;
        int idx;
        if (len <= 1) return 0;
        mid = len / 2;
        idx = s[0] ? (mid - 1 - int'(s / 2)) : (mid + int'(s / 2));
        if (idx < 0) idx = 0;
        if (idx > int'(len) - 1) idx = len - 1;
        return idx;
    endfunction

    task automatic note_on(logic [6:0] k, logic [6:0] v);
        for (int i = 0; i < sh_count; i++) begin
            if (sh_keys[i] == k) begin
                for (int j = i; j < sh_count - 1; j++) begin
                    sh_keys[j] = sh_keys[j + 1];
                    sh_strikes[j] = sh_strikes[j + 1];
                end
                sh_keys[sh_count - 1] = k;
                sh_strikes[sh_count - 1] = v;
                return;
            end
        end
        if (sh_count >= TABLE_DEPTH) begin
            for (int j = 0; j < TABLE_DEPTH - 1; j++) begin
                sh_keys[j] = sh_keys[j + 1];
                sh_strikes[j] = sh_strikes[j + 1];
            end
            sh_count = TABLE_DEPTH - 1;
        end
        sh_keys[sh_count] = k;
        sh_strikes[sh_count] = v;
        sh_count++;
    endtask

    task automatic note_off(logic [6:0] k);
        int w;
        w = 0;
        for (int i = 0; i < sh_count; i++) begin
            if (sh_keys[i] != k) begin
                sh_keys[w] = sh_keys[i];
                sh_strikes[w] = sh_strikes[i];
                w++;
            end
        end
        sh_count = w;
    endtask

    task automatic play_event(t_note_event ev);
        int unsigned ord[TABLE_DEPTH];
        int unsigned len, octs, total, s, oct, idx, cur, j, sh, refl, r, sw, shifted;
        int          n;
        t_played_note pn;
        case (ev.cmd)
            CMD_ON:  note_on(ev.key, ev.strike);
            CMD_OFF: note_off(ev.key);
            CMD_ALL: sh_count = 0;
            default: begin
                len = sh_count;
                if (len == 0 || sh_mode > PM_CHORD) return;
                octs = (sh_span == 0) ? 1 : sh_span;
                for (int i = 0; i < len; i++) ord[i] = i;
                if (sh_mode != PM_PLAYED) begin
                    for (int i = 1; i < len; i++) begin
                        cur = ord[i];
                        j = i;
                        while (j > 0 && sh_keys[ord[j - 1]] > sh_keys[cur]) begin
                            ord[j] = ord[j - 1];
                            j--;
                        end
                        ord[j] = cur;
                    end
                end
                if (sh_mode == PM_CHORD) begin
                    sh = sh_steps % octs;
                    sh_steps++;
                    n = 0;
                    for (int i = 0; i < len && n < RESULT_CAP; i++) begin
                        shifted = sh_keys[ord[i]] + SEMITONES * sh;
                        if (shifted <= TOP_KEY) begin
                            pn.key = shifted[6:0];
                            pn.strike = sh_strikes[ord[i]];
                            pn.last = 1'b0;
                            expected_notes.push_back(pn);
                            n++;
                        end
                    end
                    if (n > 0) expected_notes[$].last = 1'b1;
                    return;
                end
                total = len * octs;
                s = sh_steps % total;
                case (sh_mode)
                    PM_DOWN: begin
                        oct = (octs - 1) - s / len;
                        idx = (len - 1) - s % len;
                    end
                    PM_UPDOWN: begin
                        refl = (total > 1) ? (2 * total - 2) : 1;
                        r = sh_steps % refl;
                        sw = (r >= total) ? (2 * total - 2 - r) : r;
                        oct = sw / len;
                        idx = sw % len;
                    end
                    PM_CONVERGE: begin
                        sw = walk_in(s, total);
                        oct = sw / len;
                        idx = sw % len;
                    end
                    PM_DIVERGE: begin
                        sw = walk_out(s, total);
                        oct = sw / len;
                        idx = sw % len;
                    end
                    PM_INSIDE: begin
                        oct = s / len;
                        idx = walk_in(s % len, len);
                    end
                    PM_OUTSIDE: begin
                        oct = s / len;
                        idx = (len - 1) - walk_in(s % len, len);
                    end
                    default: begin
                        oct = s / len;
                        idx = s % len;
                    end
                endcase
                sh_steps++;
                if (idx >= len) idx = len - 1;
                shifted = sh_keys[ord[idx]] + SEMITONES * oct;
                if (shifted > TOP_KEY) return;
                pn.key = shifted[6:0];
                pn.strike = sh_strikes[ord[idx]];
                pn.last = 1'b1;
                expected_notes.push_back(pn);
            end
        endcase
    endtask

    // driver
    always @(posedge i_clk) begin
        t_note_event ev;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                play_event(t_note_event'{cmd: s_axis_tuser, key: s_axis_tdata[6:0],
                                         strike: s_axis_tdata[13:7]});
            if ((!s_axis_tvalid || s_axis_tready) && pending_events.size() > 0
                    && (calm || $urandom_range(99) >= 23)) begin
                ev = pending_events.pop_front();
                s_axis_tuser <= ev.cmd;
                s_axis_tdata <= {2'b00, ev.strike, ev.key};
                s_axis_tvalid <= 1'b1;
            end else if (s_axis_tready) begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_played_note want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_notes.size() == 0) begin
                    $error("unexpected note transfer key=%0d", m_axis_tdata[6:0]);
                    fail_count++;
                end else begin
                    want = expected_notes.pop_front();
                    if (m_axis_tdata[6:0] !== want.key) begin
                        $error("out_key expected %0d got %0d", want.key, m_axis_tdata[6:0]);
                        fail_count++;
                    end
                    if (m_axis_tdata[13:7] !== want.strike) begin
                        $error("out_strike expected %0d got %0d",
                               want.strike, m_axis_tdata[13:7]);
                        fail_count++;
                    end
                    if (m_axis_tlast !== want.last) begin
                        $error("final_flag expected %0d got %0d", want.last, m_axis_tlast);
                        fail_count++;
                    end
                end
            end
            m_axis_tready <= calm || $urandom_range(99) >= 23;
        end
    end

    task automatic queue_event(logic [1:0] c, logic [6:0] k, logic [6:0] v);
        pending_events.push_back({c, k, v});
    endtask

    task automatic wait_drained();
        while (pending_events.size() > 0 || s_axis_tvalid || expected_notes.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [3:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        if (idx == REG_MODE) sh_mode = val;
        else sh_span = val[1:0];
    endtask

    task automatic set_pattern(logic [3:0] mode, logic [3:0] span);
        wait_drained();
        write_reg(REG_MODE, mode);
        write_reg(REG_SPAN, span);
    endtask

    // random phase: mostly note traffic on a small key pool plus ticks
    task automatic random_phase(int n);
        logic [6:0] pool[6];
        int         base, pick;
        base = $urandom_range(3) == 0 ? $urandom_range(127, 90) : $urandom_range(90);
        foreach (pool[i]) pool[i] = 7'((base + $urandom_range(20)) % 128);
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(99);
            if (pick < 38)
                queue_event(CMD_ON, $urandom_range(4) == 0 ? 7'($urandom_range(127))
                            : pool[$urandom_range(5)], 7'($urandom_range(127)));
            else if (pick < 52)
                queue_event(CMD_OFF, pool[$urandom_range(5)], 7'($urandom_range(127)));
            else if (pick < 55)
                queue_event(CMD_ALL, 7'($urandom_range(127)), 7'($urandom_range(127)));
            else
                queue_event(CMD_TICK, 7'($urandom_range(127)), 7'($urandom_range(127)));
        end
    endtask

    initial begin
        logic [3:0] modes[18];
        modes = '{PM_UP, PM_DOWN, PM_UPDOWN, PM_PLAYED, PM_CONVERGE,
                  PM_DIVERGE, PM_INSIDE, PM_OUTSIDE, PM_CHORD, PM_CHORD,
                  PM_UPDOWN, PM_CONVERGE, PM_DIVERGE, PM_INSIDE,
                  PM_OUTSIDE, PM_BAD_LO, PM_BAD_HI, PM_UP};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: tick on empty table, extremes, duplicates, overflow of table
        queue_event(CMD_TICK, 7'd0, 7'd0);
        queue_event(CMD_ON, 7'd127, 7'd0);
        queue_event(CMD_ON, 7'd0, 7'd127);
        queue_event(CMD_ON, 7'd64, 7'd85);
        queue_event(CMD_ON, 7'd0, 7'd42);
        queue_event(CMD_TICK, 7'd127, 7'd127);
        queue_event(CMD_TICK, 7'd0, 7'd0);
        queue_event(CMD_TICK, 7'd0, 7'd0);
        queue_event(CMD_OFF, 7'd64, 7'd0);
        queue_event(CMD_TICK, 7'd0, 7'd0);
        queue_event(CMD_ALL, 7'd0, 7'd0);
        queue_event(CMD_TICK, 7'd0, 7'd0);
        for (int i = 0; i < 18; i++)
            queue_event(CMD_ON, 7'(100 + i), 7'(i * 7));
        wait_drained();
        // chord over a full table at three octaves, high notes get dropped
        set_pattern(PM_CHORD, 4'd3);
        repeat (3) queue_event(CMD_TICK, 7'd0, 7'd0);
        set_pattern(PM_UP, 4'd0);
        queue_event(CMD_TICK, 7'd0, 7'd0);
        queue_event(CMD_ALL, 7'd0, 7'd0);

        for (int p = 0; p < 18; p++) begin
            set_pattern(modes[p], 4'($urandom_range(3)) | (p % 4 == 3 ? 4'd0 : 4'd1));
            calm = (p == 9);
            random_phase(10);
        end
        set_pattern(PM_UP, 4'd3);
        calm = 1'b0;
        wait_drained();

        if (fail_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    initial begin
        #1500000;
        $display("tb_top NOT OK");
        $finish;
    end
endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/ans_pkg.sv
rtl/core/ans_ctrl.sv
rtl/core/ans_dpath.sv
rtl/core/arpeggio_note_sequencer.sv
test/tb_top.sv
